@@ hdl/rcfd_pkg.sv @@
`timescale 1ns / 1ps

package rcfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN  = 18;
    localparam int unsigned COUNT_SAT  = 19;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned CH_W       = 11;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned OUT_DATA_W = 136;

    // Register map, index from paddr[3:2]
    localparam logic [1:0] REG_DEADBAND      = 2'd0;
    localparam logic [1:0] REG_CHANNEL_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [9:0]  DEADBAND_RST      = 10'd5;
    localparam logic [9:0]  CHANNEL_LIMIT_RST = 10'd660;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // Request kinds on the input stream
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [WORD_W-1:0] WHEEL_OFFSET = 16'd1024;

    typedef struct packed {
        logic [9:0]  deadband;
        logic [9:0]  channel_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]   ch1;
        logic [CH_W-1:0]   ch2;
        logic [CH_W-1:0]   ch3;
        logic [CH_W-1:0]   ch4;
        logic [1:0]        switch_one;
        logic [1:0]        switch_two;
        logic [WORD_W-1:0] mouse_x;
        logic [WORD_W-1:0] mouse_y;
        logic [WORD_W-1:0] mouse_buttons;
        logic [WORD_W-1:0] key_code;
        logic [WORD_W-1:0] wheel;
        logic              link_ok;
    } result_t;

    // Center a raw stick value: subtracting 1024 from an 11-bit value
    // is a flip of its top bit in two's complement.
    function automatic logic [CH_W-1:0] center_raw(input logic [CH_W-1:0] raw);
        center_raw = {~raw[CH_W-1], raw[CH_W-2:0]};
    endfunction

    // Magnitude of a centered value, read as unsigned so 1024 still fits
    function automatic logic [CH_W-1:0] mag_of(input logic [CH_W-1:0] c);
        mag_of = c[CH_W-1] ? (~c + 1'b1) : c;
    endfunction

endpackage

@@ hdl/rcfd_cfg.sv @@
`timescale 1ns / 1ps

module rcfd_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rcfd_pkg::cfg_t     cfg
);
    import rcfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Decode the write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DEADBAND:      cfg_next.deadband      = pwdata[9:0];
                REG_CHANNEL_LIMIT: cfg_next.channel_limit = pwdata[9:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband      <= DEADBAND_RST;
            cfg_reg.channel_limit <= CHANNEL_LIMIT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEADBAND:      prdata = {22'd0, cfg_reg.deadband};
            REG_CHANNEL_LIMIT: prdata = {22'd0, cfg_reg.channel_limit};
            REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_reg.timeout_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/rcfd_core.sv @@
`timescale 1ns / 1ps

module rcfd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  rcfd_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  logic                item_op,
    input  logic [7:0]          item_byte,
    input  logic                item_last,
    input  logic                step,
    output logic                has_result,
    output rcfd_pkg::result_t   result
);
    import rcfd_pkg::*;

    logic [7:0]         store_reg [FRAME_LEN];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [15:0]        left_reg;
    logic [15:0]        left_next;
    logic               running_reg;
    logic               running_next;

    logic [7:0]      d [FRAME_LEN];
    logic [CH_W-1:0] raw [4];
    logic [CH_W-1:0] cen [4];
    logic [CH_W-1:0] mag [4];
    logic [CH_W-1:0] chv [4];
    logic [3:0]      fault;
    logic            frame_ok;
    logic            expire;
    logic            good;

    // Frame bytes: the last one comes straight from the current request
    always_comb
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            d[i] = store_reg[i];
        end
        d[FRAME_LEN-1] = item_byte;
    end

    // Stick fields straddle byte borders
    assign raw[0] = {d[1][2:0], d[0]};
    assign raw[1] = {d[2][5:0], d[1][7:3]};
    assign raw[2] = {d[4][0], d[3], d[2][7:6]};
    assign raw[3] = {d[5][3:0], d[4][7:1]};

    // Center, apply deadband, check limit
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cen[k]   = center_raw(raw[k]);
            mag[k]   = mag_of(cen[k]);
            if (mag[k] <= {1'b0, cfg.deadband})
            begin
                chv[k]   = '0;
                fault[k] = 1'b0;
            end
            else
            begin
                chv[k]   = cen[k];
                fault[k] = mag[k] > {1'b0, cfg.channel_limit};
            end
        end
    end

    assign frame_ok   = (item_op == OP_BYTE) && item_last &&
                        (count_reg == COUNT_W'(FRAME_LEN - 1));
    assign expire     = (item_op == OP_TICK) && running_reg && (left_reg[15:1] == '0);
    assign good       = frame_ok && (fault == 4'b0000);
    assign has_result = item_valid && (frame_ok || expire);

    // Result: decoded frame for a good frame, all zero otherwise
    always_comb
    begin
        result = '0;
        if (good)
        begin
            result.ch1           = chv[0];
            result.ch2           = chv[1];
            result.ch3           = chv[2];
            result.ch4           = chv[3];
            result.switch_one    = d[5][7:6];
            result.switch_two    = d[5][5:4];
            result.mouse_x       = {d[7], d[6]};
            result.mouse_y       = {d[9], d[8]};
            result.mouse_buttons = {d[13], d[12]};
            result.key_code      = {d[15], d[14]};
            result.wheel         = {d[17], d[16]} - WHEEL_OFFSET;
            result.link_ok       = 1'b1;
        end
    end

    // Byte count and timer next state
    always_comb
    begin
        count_next   = count_reg;
        left_next    = left_reg;
        running_next = running_reg;
        if (item_op == OP_TICK)
        begin
            if (running_reg)
            begin
                if (expire)
                begin
                    left_next    = '0;
                    running_next = 1'b0;
                end
                else
                begin
                    left_next = left_reg - 16'd1;
                end
            end
        end
        else
        begin
            if (item_last)
            begin
                count_next = '0;
            end
            else if (count_reg < COUNT_W'(COUNT_SAT))
            begin
                count_next = count_reg + 1'b1;
            end
            if (good)
            begin
                left_next    = cfg.timeout_ticks;
                running_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            running_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            running_reg <= running_next;
        end
    end

    // Hold received bytes; drop those beyond the frame length
    always_ff @(posedge clk)
    begin
        if (step && (item_op == OP_BYTE) && (count_reg < COUNT_W'(FRAME_LEN)))
        begin
            store_reg[count_reg] <= item_byte;
        end
    end

endmodule

@@ hdl/remote_control_frame_decoder_unit.sv @@
`timescale 1ns / 1ps

// Remote-control receiver frame decoder.
// Input stream (s_*): one request per received UART byte or per time tick.
//   s_tuser = 0 byte, 1 tick; s_tdata[7:0] = byte; s_tlast marks the last byte
//   of a frame. An 18-byte frame yields one result; other lengths yield none.
// Output stream (m_*): decoded sticks, switches, mouse, keys, wheel and
//   link_ok. A fault frame (stick beyond channel_limit) or a timer expiry
//   yields an all-zero result with link_ok 0.
// APB port: deadband at 0x0, channel_limit at 0x4, timeout_ticks at 0x8.
// Path: a request is registered in the input register, then decoded into
//   the output register, which drives m_tvalid.
// Throughput: one request per cycle while s_tready is high; the decode is a
//   single pass over the registered byte and the 17 stored frame bytes.
// Reset: byte count and timer clear, registers take their defaults, no
//   result is pending. Frame bytes are not cleared; a decode only reads
//   bytes written in the same frame.
// Stall: while m_tready is low a held result stays put; a request that
//   causes no result still moves on, one that causes a result waits in the
//   input register, and s_tready drops once that register is full.
module remote_control_frame_decoder_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] op
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [10:0] ch1, [21:11] ch2, [32:22] ch3, [43:33] ch4, [45:44] switch_one,
    // [47:46] switch_two, [63:48] mouse_x, [79:64] mouse_y,
    // [95:80] mouse_buttons, [111:96] key_code, [127:112] wheel,
    // [128] link_ok, [135:129] zero
    output logic [135:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rcfd_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    has_result;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;

    logic out_free;
    logic step;

    rcfd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcfd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item_op    (in_op_reg),
        .item_byte  (in_byte_reg),
        .item_last  (in_last_reg),
        .step       (step),
        .has_result (has_result),
        .result     (result)
    );

    // Advance the input register unless its result has nowhere to go
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!has_result || out_free);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request payload and result payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && has_result)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_data_reg.link_ok,
                       out_data_reg.wheel,
                       out_data_reg.key_code,
                       out_data_reg.mouse_buttons,
                       out_data_reg.mouse_y,
                       out_data_reg.mouse_x,
                       out_data_reg.switch_two,
                       out_data_reg.switch_one,
                       out_data_reg.ch4,
                       out_data_reg.ch3,
                       out_data_reg.ch2,
                       out_data_reg.ch1};

endmodule
